// ===== sv/ftach_pkg.sv =====
// Shared types and constants for the fan tachometer rpm meter.
`timescale 1ns / 1ps
package ftach_pkg;

  localparam int CountW  = 32;  // accepted edge count
  localparam int TimeW   = 32;  // microsecond timestamp
  localparam int MinPW   = 16;
  localparam int PprW    = 4;
  localparam int MsW     = 16;
  localparam int RpmMaxW = 16;
  localparam int RpmW    = 17;

  localparam int MulAW   = 32;
  localparam int MulBW   = 16;
  localparam int MulPW   = MulAW + MulBW;

  localparam int NumW    = CountW + MulBW;   // count * 60000
  localparam int DenW    = PprW + MsW;       // ppr * ms
  localparam int DivNW   = NumW + 2;         // 2*num + den
  localparam int DivDW   = DenW + 1;         // 2*den

  // 60 s * 1000 ms
  localparam logic [MulBW-1:0] RpmScale  = 16'd60000;
  // ceil(2^18 / 5): floor(x/5) = (x * Div5Recip) >> 18, exact for 16-bit x
  localparam logic [MulBW-1:0] Div5Recip = 16'd52429;
  localparam int               Div5Shift = 18;

  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  // register indexes
  localparam logic [2:0] RegMinPulse = 3'd0;
  localparam logic [2:0] RegPpr      = 3'd1;
  localparam logic [2:0] RegSampleMs = 3'd2;
  localparam logic [2:0] RegRpmMax   = 3'd3;
  localparam logic [2:0] RegDisabled = 3'd4;

  // input commands
  localparam logic CmdEdge   = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic [MinPW-1:0]   min_pulse_us;
    logic [PprW-1:0]    pulses_per_rev;
    logic [MsW-1:0]     sample_ms;
    logic [RpmMaxW-1:0] rpm_max;
    logic               disabled;
  } cfg_t;

  typedef struct packed {
    logic done;  // one-cycle pulse after the last step
    logic ovf;   // quotient does not fit in RpmW bits
  } div_stat_t;

endpackage

// ===== sv/ftach_cfg_regs.sv =====
// APB-style configuration register file for the fan tachometer.
`timescale 1ns / 1ps
module ftach_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ftach_pkg::CfgAddrW-1:0]     paddr,
  input  logic [ftach_pkg::CfgDataW-1:0]     pwdata,
  output logic [ftach_pkg::CfgDataW-1:0]     prdata,
  output logic                               pready,
  output ftach_pkg::cfg_t                    cfg_o
);

  ftach_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ftach_pkg::RegMinPulse: cfg_d.min_pulse_us   = pwdata[ftach_pkg::MinPW-1:0];
        ftach_pkg::RegPpr:      cfg_d.pulses_per_rev = pwdata[ftach_pkg::PprW-1:0];
        ftach_pkg::RegSampleMs: cfg_d.sample_ms      = pwdata[ftach_pkg::MsW-1:0];
        ftach_pkg::RegRpmMax:   cfg_d.rpm_max        = pwdata[ftach_pkg::RpmMaxW-1:0];
        ftach_pkg::RegDisabled: cfg_d.disabled       = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ftach_pkg::RegMinPulse: prdata = 32'(cfg_q.min_pulse_us);
      ftach_pkg::RegPpr:      prdata = 32'(cfg_q.pulses_per_rev);
      ftach_pkg::RegSampleMs: prdata = 32'(cfg_q.sample_ms);
      ftach_pkg::RegRpmMax:   prdata = 32'(cfg_q.rpm_max);
      ftach_pkg::RegDisabled: prdata = 32'(cfg_q.disabled);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_us   <= 16'd1000;
      cfg_q.pulses_per_rev <= 4'd2;
      cfg_q.sample_ms      <= 16'd1000;
      cfg_q.rpm_max        <= 16'd3000;
      cfg_q.disabled       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/ftach_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ftach_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ftach_pkg::DivNW-1:0]     num_i,
  input  logic [ftach_pkg::DivDW-1:0]     den_i,
  output logic [ftach_pkg::RpmW-1:0]      quot_o,
  output ftach_pkg::div_stat_t            stat_o
);

  localparam int CntW = $clog2(ftach_pkg::DivNW + 1);
  localparam logic [CntW-1:0] NumSteps = CntW'(ftach_pkg::DivNW);

  logic [ftach_pkg::DivNW-1:0] n_q;
  logic [ftach_pkg::DivDW-1:0] d_q;
  logic [ftach_pkg::DivDW-1:0] r_q, r_d;
  logic [ftach_pkg::RpmW-1:0]  q_q;
  logic                        ovf_q;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [ftach_pkg::DivDW:0]   r_sh;
  logic                        q_bit;

  // trial subtract; remainder stays below the divisor
  always_comb begin
    r_sh  = {r_q, n_q[ftach_pkg::DivNW-1]};
    q_bit = (r_sh >= {1'b0, d_q});
    r_d   = q_bit ? ftach_pkg::DivDW'(r_sh - {1'b0, d_q}) : r_sh[ftach_pkg::DivDW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == NumSteps - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      r_q   <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[ftach_pkg::DivNW-2:0], 1'b0};
      r_q   <= r_d;
      q_q   <= {q_q[ftach_pkg::RpmW-2:0], q_bit};
      ovf_q <= ovf_q | q_q[ftach_pkg::RpmW-1];
    end
  end

  assign quot_o      = q_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// ===== sv/fan_tach_rpm_meter_core.sv =====
// Top level of the fan tachometer rpm meter: edge counter, sequencer, shared multiplier, divider, config registers.
`timescale 1ns / 1ps
//
//  channel  | beat fields            | handshake
//  ---------+------------------------+--------------------------------
//  in       | cmd_i, now_us_i        | in_valid_i  / in_stall_o
//  out      | rpm_o, valid_res_o     | out_valid_o / out_stall_i
//  cfg      | paddr, pwdata, prdata  | psel, penable, pwrite, pready
//
//  An edge beat is taken whenever the sequencer is idle. After a sample
//  beat is taken the sequencer holds in_stall_o: the one 32x16 multiplier
//  does count*60000 in the accept cycle, then ppr*ms in S_DEN and the
//  rpm_max/5 reciprocal in S_LIM; the bit-serial divider works through the
//  50-bit numerator and then raises its done flag; then S_OUT loads the
//  output register, waiting while a previous result there is still stalled.
//  The finished result waits in the output register under out_stall_i; edges
//  keep being accepted then. Reset is asynchronous, active low; no clearing
//  pass is needed.
//
module fan_tach_rpm_meter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [ftach_pkg::TimeW-1:0]     now_us_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ftach_pkg::RpmW-1:0]      rpm_o,
  output logic                            valid_res_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ftach_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ftach_pkg::CfgDataW-1:0]  pwdata,
  output logic [ftach_pkg::CfgDataW-1:0]  prdata,
  output logic                            pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEN  = 3'd1;  // multiplier: ppr * ms
  localparam logic [2:0] S_LIM  = 3'd2;  // multiplier: rpm_max reciprocal, divider start
  localparam logic [2:0] S_DIV  = 3'd3;  // wait for divider
  localparam logic [2:0] S_OUT  = 3'd4;  // hand result to output register

  ftach_pkg::cfg_t      cfg;
  ftach_pkg::div_stat_t div_stat;

  logic [2:0] state_q, state_d;

  logic [ftach_pkg::CountW-1:0]  pulse_count_q;
  logic [ftach_pkg::TimeW-1:0]   last_edge_q;
  logic [ftach_pkg::NumW-1:0]    num_q;
  logic [ftach_pkg::DenW-1:0]    den_q;
  logic [ftach_pkg::RpmW-1:0]    lim_q;

  logic                          out_valid_q;
  logic [ftach_pkg::RpmW-1:0]    rpm_q;
  logic                          valid_res_q;

  logic [ftach_pkg::MulAW-1:0]   mul_a;
  logic [ftach_pkg::MulBW-1:0]   mul_b;
  logic [ftach_pkg::MulPW-1:0]   mul_p;

  logic                          in_fire;
  logic                          edge_ok;
  logic                          sample_go;
  logic [ftach_pkg::TimeW-1:0]   elapsed;
  logic [ftach_pkg::PprW-1:0]    ppr_eff;
  logic [ftach_pkg::MsW-1:0]     ms_eff;
  logic                          div_start;
  logic [ftach_pkg::DivNW-1:0]   div_num;
  logic [ftach_pkg::DivDW-1:0]   div_den;
  logic [ftach_pkg::RpmW-1:0]    quot;
  logic                          glitch;
  logic                          out_free;

  ftach_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;

  // debounce: wrapping elapsed time since the last counted edge
  assign elapsed   = now_us_i - last_edge_q;
  assign edge_ok   = in_fire & (cmd_i == ftach_pkg::CmdEdge) & ~cfg.disabled &
                     (elapsed >= ftach_pkg::TimeW'(cfg.min_pulse_us));
  assign sample_go = in_fire & (cmd_i == ftach_pkg::CmdSample) & ~cfg.disabled;

  // zero ppr / ms treated as 1
  assign ppr_eff = (cfg.pulses_per_rev == '0) ? ftach_pkg::PprW'(1) : cfg.pulses_per_rev;
  assign ms_eff  = (cfg.sample_ms == '0) ? ftach_pkg::MsW'(1) : cfg.sample_ms;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_DEN: begin
        mul_a = ftach_pkg::MulAW'(ppr_eff);
        mul_b = ms_eff;
      end
      S_LIM: begin
        mul_a = ftach_pkg::MulAW'(cfg.rpm_max);
        mul_b = ftach_pkg::Div5Recip;
      end
      default: begin
        mul_a = pulse_count_q;
        mul_b = ftach_pkg::RpmScale;
      end
    endcase
  end
  assign mul_p = ftach_pkg::MulPW'(mul_a) * ftach_pkg::MulPW'(mul_b);

  // round half up: (2*num + den) / (2*den)
  assign div_start = (state_q == S_LIM);
  assign div_num   = {1'b0, num_q, 1'b0} + ftach_pkg::DivNW'(den_q);
  assign div_den   = {den_q, 1'b0};

  ftach_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  assign glitch   = div_stat.ovf | (quot > lim_q);
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (sample_go) state_d = S_DEN;
      S_DEN:  state_d = S_LIM;
      S_LIM:  state_d = S_DIV;
      S_DIV:  if (div_stat.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pulse_count_q <= '0;
      last_edge_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (edge_ok) begin
        pulse_count_q <= pulse_count_q + 1'b1;
        last_edge_q   <= now_us_i;
      end else if (sample_go) begin
        pulse_count_q <= '0;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      num_q <= mul_p[ftach_pkg::NumW-1:0];
    end
    if (state_q == S_DEN) begin
      den_q <= mul_p[ftach_pkg::DenW-1:0];
    end
    if (state_q == S_LIM) begin
      // floor(rpm_max*6/5) = rpm_max + floor(rpm_max/5)
      lim_q <= ftach_pkg::RpmW'(cfg.rpm_max) +
               ftach_pkg::RpmW'(mul_p[ftach_pkg::Div5Shift +: ftach_pkg::RpmMaxW]);
    end
    if (state_q == S_OUT && out_free) begin
      rpm_q       <= glitch ? '0 : quot;
      valid_res_q <= ~glitch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rpm_o       = rpm_q;
  assign valid_res_o = valid_res_q;

endmodule
